/* rtl/qalu_pkg.sv */
// ----------------------------------------------------------------------------
// qalu_pkg
// Types and constants shared by the quaternion ALU pipeline.
// ----------------------------------------------------------------------------
package qalu_pkg;

  // operation codes
  localparam logic [3:0] FN_NEG  = 4'd0;
  localparam logic [3:0] FN_ADD  = 4'd1;
  localparam logic [3:0] FN_SUB  = 4'd2;
  localparam logic [3:0] FN_CMUL = 4'd3;
  localparam logic [3:0] FN_HMUL = 4'd4;
  localparam logic [3:0] FN_DIV  = 4'd5;
  localparam logic [3:0] FN_CONJ = 4'd6;
  localparam logic [3:0] FN_INV  = 4'd7;
  localparam logic [3:0] FN_REAL = 4'd8;
  localparam logic [3:0] FN_IMAG = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam int PROD_W = 48;  // floored product, Q32.16
  localparam int PRE_W  = 52;  // unsaturated result
  localparam int DVD_W  = 48;  // dividend magnitude, also quotient bits
  localparam int DVS_W  = 50;  // divisor magnitude
  localparam int NSTEP  = DVD_W;
  localparam int LAT    = NSTEP + 3;

  localparam logic signed [PRE_W-1:0] QMAX_W = {{(PRE_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PRE_W-1:0] QMIN_W = {{(PRE_W-31){1'b1}}, 31'b0};

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] a_real;
    logic signed [31:0] a_i;
    logic signed [31:0] a_j;
    logic signed [31:0] a_k;
    logic signed [31:0] b_real;
    logic signed [31:0] b_i;
    logic signed [31:0] b_j;
    logic signed [31:0] b_k;
  } qalu_in_t;

  typedef struct packed {
    logic signed [31:0] r_real;
    logic signed [31:0] r_i;
    logic signed [31:0] r_j;
    logic signed [31:0] r_k;
    logic [1:0]         status;
  } qalu_out_t;

  typedef struct packed {
    logic [3:0]                   func;
    logic [3:0][31:0]             a;
    logic [3:0][31:0]             b;
    logic [3:0][3:0][PROD_W-1:0]  hp;   // hp[i][j] = floor(a_i * b_j)
    logic [3:0][PROD_W-1:0]       sq;   // floor(a_i * a_i)
  } qalu_mul_t;

  typedef struct packed {
    logic                   is_div;
    logic                   dz;
    logic [3:0]             qneg;
    logic [3:0][PRE_W-1:0]  pre;
  } qalu_side_t;

  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [DVD_W-1:0] nq;   // dividend bits shift out, quotient bits shift in
  } qalu_lane_t;

  typedef struct packed {
    qalu_side_t             side;
    logic [DVS_W-1:0]       dvs;
    qalu_lane_t [3:0]       lane;
  } qalu_div_t;

  // one restoring division step
  function automatic qalu_lane_t div_step(qalu_lane_t x, logic [DVS_W-1:0] d);
    logic [DVS_W:0] sh;
    logic [DVS_W:0] df;
    qalu_lane_t     y;
    sh = {x.rem, x.nq[DVD_W-1]};
    df = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      y.rem = df[DVS_W-1:0];
      y.nq  = {x.nq[DVD_W-2:0], 1'b1};
    end else begin
      y.rem = sh[DVS_W-1:0];
      y.nq  = {x.nq[DVD_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

/* rtl/qalu_mul.sv */
// ----------------------------------------------------------------------------
// qalu_mul
// Stage 1: all 32x32 products, floored to Q32.16 and registered.
// ----------------------------------------------------------------------------
module qalu_mul import qalu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  qalu_in_t  cmd,
  output logic      out_vld,
  output qalu_mul_t m
);

  logic signed [31:0] a [4];
  logic signed [31:0] b [4];
  logic signed [63:0] pf [4][4];
  logic signed [63:0] ps [4];

  always_comb begin
    a[0] = cmd.a_real; a[1] = cmd.a_i; a[2] = cmd.a_j; a[3] = cmd.a_k;
    b[0] = cmd.b_real; b[1] = cmd.b_i; b[2] = cmd.b_j; b[3] = cmd.b_k;
    for (int i = 0; i < 4; i++) begin
      ps[i] = a[i] * a[i];
      for (int j = 0; j < 4; j++) begin
        pf[i][j] = a[i] * b[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    m.func <= cmd.func;
    for (int i = 0; i < 4; i++) begin
      m.a[i]  <= a[i];
      m.b[i]  <= b[i];
      m.sq[i] <= ps[i][63:16];
      for (int j = 0; j < 4; j++) begin
        m.hp[i][j] <= pf[i][j][63:16];
      end
    end
  end

endmodule

/* rtl/qalu_sum.sv */
// ----------------------------------------------------------------------------
// qalu_sum
// Stage 2: sums and simple results, and divider operand setup.
// ----------------------------------------------------------------------------
module qalu_sum import qalu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  qalu_mul_t m,
  output logic      out_vld,
  output qalu_div_t d
);

  logic signed [PRE_W-1:0] av [4];
  logic signed [PRE_W-1:0] bv [4];
  logic signed [PRE_W-1:0] e [4][4];
  logic signed [PRE_W-1:0] norm;
  logic signed [PRE_W-1:0] bmag;
  logic signed [PRE_W-1:0] num [4];
  logic signed [PRE_W-1:0] mag [4];
  logic signed [PRE_W-1:0] pre [4];
  logic                    is_div;
  logic                    dz;
  logic                    dneg;
  logic [DVS_W-1:0]        dvs;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      av[i] = PRE_W'($signed(m.a[i]));
      bv[i] = PRE_W'($signed(m.b[i]));
      for (int j = 0; j < 4; j++) begin
        e[i][j] = PRE_W'($signed(m.hp[i][j]));
      end
    end
    norm = PRE_W'($signed(m.sq[0])) + PRE_W'($signed(m.sq[1]))
         + PRE_W'($signed(m.sq[2])) + PRE_W'($signed(m.sq[3]));
    bmag = bv[0][PRE_W-1] ? -bv[0] : bv[0];
    for (int n = 0; n < 4; n++) begin
      pre[n] = '0;
      num[n] = '0;
    end
    is_div = 1'b0;
    dz     = 1'b0;
    dneg   = 1'b0;
    dvs    = '0;
    case (m.func)
      FN_NEG: begin
        for (int n = 0; n < 4; n++) pre[n] = -av[n];
      end
      FN_ADD: begin
        for (int n = 0; n < 4; n++) pre[n] = av[n] + bv[n];
      end
      FN_SUB: begin
        for (int n = 0; n < 4; n++) pre[n] = av[n] - bv[n];
      end
      FN_CMUL: begin
        for (int n = 0; n < 4; n++) pre[n] = e[n][n];
      end
      FN_HMUL: begin
        pre[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
        pre[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
        pre[2] = e[0][2] + e[2][0] + e[3][1] - e[1][3];
        pre[3] = e[0][3] + e[3][0] + e[1][2] - e[2][1];
      end
      FN_DIV: begin
        is_div = 1'b1;
        dz     = (bv[0] == '0);
        dvs    = bmag[DVS_W-1:0];
        dneg   = bv[0][PRE_W-1];
        for (int n = 0; n < 4; n++) num[n] = av[n];
      end
      FN_CONJ: begin
        pre[0] = av[0];
        for (int n = 1; n < 4; n++) pre[n] = -av[n];
      end
      FN_INV: begin
        is_div = 1'b1;
        dz     = (norm == '0);
        dvs    = norm[DVS_W-1:0];
        num[0] = av[0];
        for (int n = 1; n < 4; n++) num[n] = -av[n];
      end
      FN_REAL: begin
        pre[0] = av[0];
      end
      FN_IMAG: begin
        for (int n = 1; n < 4; n++) pre[n] = av[n];
      end
      default: begin
        pre[0] = '0;
      end
    endcase
    for (int n = 0; n < 4; n++) begin
      mag[n] = num[n][PRE_W-1] ? -num[n] : num[n];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    d.side.is_div <= is_div;
    d.side.dz     <= dz;
    d.dvs         <= dvs;
    for (int n = 0; n < 4; n++) begin
      d.side.pre[n]  <= pre[n];
      d.side.qneg[n] <= num[n][PRE_W-1] ^ dneg;
      d.lane[n].rem  <= '0;
      d.lane[n].nq   <= {mag[n][31:0], 16'b0};
    end
  end

endmodule

/* rtl/qalu_div.sv */
// ----------------------------------------------------------------------------
// qalu_div
// Pipelined restoring divider: one quotient bit per stage on four lanes,
// with the rest of the result riding alongside.
// ----------------------------------------------------------------------------
module qalu_div import qalu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  qalu_div_t din,
  output logic      out_vld,
  output qalu_div_t dout
);

  qalu_div_t  stg [NSTEP];
  logic       vld [NSTEP];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSTEP; s++) vld[s] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
      for (int s = 1; s < NSTEP; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    stg[0].side <= din.side;
    stg[0].dvs  <= din.dvs;
    for (int l = 0; l < 4; l++) stg[0].lane[l] <= div_step(din.lane[l], din.dvs);
    for (int s = 1; s < NSTEP; s++) begin
      stg[s].side <= stg[s-1].side;
      stg[s].dvs  <= stg[s-1].dvs;
      for (int l = 0; l < 4; l++) stg[s].lane[l] <= div_step(stg[s-1].lane[l], stg[s-1].dvs);
    end
  end

  assign out_vld = vld[NSTEP-1];
  assign dout    = stg[NSTEP-1];

endmodule

/* rtl/qalu_out.sv */
// ----------------------------------------------------------------------------
// qalu_out
// Final stage: sign the quotients, saturate, form status, register result.
// ----------------------------------------------------------------------------
module qalu_out import qalu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_vld,
  input  qalu_div_t d,
  output logic      done,
  output qalu_out_t res
);

  logic [DVD_W:0]          q  [4];
  logic signed [DVD_W:0]   sq [4];
  logic signed [PRE_W-1:0] val [4];
  logic [3:0][31:0]        rv;
  logic                    sat;
  qalu_out_t               res_next;

  always_comb begin
    sat = 1'b0;
    for (int n = 0; n < 4; n++) begin
      q[n]  = {1'b0, d.lane[n].nq};
      sq[n] = d.side.qneg[n] ? -$signed(q[n]) : $signed(q[n]);
      val[n] = d.side.is_div ? PRE_W'(sq[n]) : $signed(d.side.pre[n]);
      if (val[n] > QMAX_W) begin
        rv[n] = QMAX_W[31:0];
        sat   = 1'b1;
      end else if (val[n] < QMIN_W) begin
        rv[n] = QMIN_W[31:0];
        sat   = 1'b1;
      end else begin
        rv[n] = val[n][31:0];
      end
    end
    if (d.side.is_div && d.side.dz) begin
      res_next = '{r_real: '0, r_i: '0, r_j: '0, r_k: '0, status: ST_DZ};
    end else begin
      res_next.r_real = rv[0];
      res_next.r_i    = rv[1];
      res_next.r_j    = rv[2];
      res_next.r_k    = rv[3];
      res_next.status = sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

/* rtl/quaternion_alu_top.sv */
// ----------------------------------------------------------------------------
// quaternion_alu_top
// Quaternion ALU in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd (opcode and operands a, b) and raise start. A transfer
//   happens on each rising edge with start high and busy low; busy is never
//   raised, so a new command may be issued every cycle.
//   Each command yields one result on res, marked by done for exactly one
//   cycle, in issue order. The path runs through the multiplier, summing,
//   48 divider and output stages; the divider yields one quotient bit per
//   stage. Every opcode takes the same path, so results never reorder.
//   One command is accepted per cycle.
//   Reset (rst, synchronous) clears all valid bits; commands in flight are
//   dropped and no done pulse follows for them.
//   The receiver cannot stall: a result is present for one cycle only.
// ----------------------------------------------------------------------------
module quaternion_alu_top import qalu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  qalu_in_t  cmd,
  output logic      done,
  output qalu_out_t res
);

  logic      acc;
  logic      m_vld;
  qalu_mul_t m;
  logic      s_vld;
  qalu_div_t s;
  logic      d_vld;
  qalu_div_t dq;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  qalu_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (acc),
    .cmd     (cmd),
    .out_vld (m_vld),
    .m       (m)
  );

  qalu_sum u_sum (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (m_vld),
    .m       (m),
    .out_vld (s_vld),
    .d       (s)
  );

  qalu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s_vld),
    .din     (s),
    .out_vld (d_vld),
    .dout    (dq)
  );

  qalu_out u_out (
    .clk    (clk),
    .rst    (rst),
    .in_vld (d_vld),
    .d      (dq),
    .done   (done),
    .res    (res)
  );

  // every result traces back to a matching transfer through the pipeline
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LAT))
    else $error("done without a matching transfer");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.status == ST_DZ) |->
      (res.r_real == '0 && res.r_i == '0 && res.r_j == '0 && res.r_k == '0))
    else $error("divide-by-zero result not cleared");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.status == ST_OK || res.status == ST_DZ || res.status == ST_SAT))
    else $error("illegal status code");

endmodule
